// ===== src/ctl_pkg.sv =====
// shared types and constants for the cursor tuple list unit
package ctl_pkg;

    localparam int WORD_W      = 32;
    localparam int TUPLE_WORDS = 5;
    localparam int TUPLE_W     = WORD_W * TUPLE_WORDS;
    localparam int MODE_W      = 4;

    // command codes carried on the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR     = 4'd0,
        MODE_INSERT    = 4'd1,
        MODE_REMOVE    = 4'd2,
        MODE_SWAP_NEXT = 4'd3,
        MODE_SWAP_PREV = 4'd4,
        MODE_FWD       = 4'd5,
        MODE_BACK      = 4'd6,
        MODE_READ      = 4'd7,
        MODE_WRITE     = 4'd8,
        MODE_CONTAINS  = 4'd9
    } mode_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_REM_RD,
        ST_REM_WR,
        ST_SWP_RD1,
        ST_SWP_RD2,
        ST_SWP_WR1,
        ST_SWP_WR2,
        ST_READ_RD,
        ST_WRITE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== src/cursor_tuple_list_unit.sv =====
// cursor tuple list unit: ordered list of five-word tuples with a cursor
// An ordered list of up to LIST_DEPTH tuples (five 32-bit words each) held in one
// memory with a single write port and a single registered read port, with a cursor
// into it. Each accepted transaction is one command (clear, insert after cursor,
// remove at cursor, swap with next or previous, move cursor, read, overwrite,
// contains) and gives exactly one result transaction reporting the list length and
// cursor after the command. A small sequencer walks the memory one entry at a time,
// so how long an item occupies the block, counted from the accepting cycle until
// s_ready returns, depends on the command: clear, cursor moves and unused codes go
// straight to the result step; read and overwrite add one memory access; a swap
// reads both entries and writes both back; insert and remove slide entries by one
// place, each slide being one memory read followed by one memory write; contains
// compares one stored entry per cycle. The single memory read and write port sets
// this pacing. The result sits in an output register, so the next command is
// accepted while a result still waits for m_ready; the sequencer only stalls at its
// final step if the previous result has not yet been taken.
// The tuple memory has no reset and needs no clearing pass: entries at or above the
// length are never read.
module cursor_tuple_list_unit
    import ctl_pkg::*;
#(
    parameter int LIST_DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // command channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [MODE_W-1:0]                   s_mode,
    input  logic [WORD_W-1:0]                   s_word_a,
    input  logic [WORD_W-1:0]                   s_word_b,
    input  logic [WORD_W-1:0]                   s_word_c,
    input  logic [WORD_W-1:0]                   s_word_d,
    input  logic [WORD_W-1:0]                   s_word_e,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [$clog2(LIST_DEPTH+1)-1:0]     m_list_length,
    output logic [$clog2(LIST_DEPTH+1)-1:0]     m_cursor_pos,
    output logic                                m_read_valid,
    output logic                                m_found,
    output logic [WORD_W-1:0]                   m_out_a,
    output logic [WORD_W-1:0]                   m_out_b,
    output logic [WORD_W-1:0]                   m_out_c,
    output logic [WORD_W-1:0]                   m_out_d,
    output logic [WORD_W-1:0]                   m_out_e
);

    // count and cursor width holds the depth itself; address width indexes the memory
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // tuple memory, no reset
    logic [TUPLE_W-1:0] mem [LIST_DEPTH];

    // sequencer and list state
    state_t             state_reg,   state_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [CNT_W-1:0]   cursor_reg,  cursor_next;
    logic [CNT_W-1:0]   idx_reg,     idx_next;
    logic [CNT_W-1:0]   pos_reg,     pos_next;
    logic [TUPLE_W-1:0] tuple_reg,   tuple_next;
    logic [TUPLE_W-1:0] hold_reg,    hold_next;
    logic               rvalid_reg,  rvalid_next;
    logic               hit_reg,     hit_next;
    logic               pend_reg,    pend_next;
    logic [TUPLE_W-1:0] rd_data_reg;

    // result register
    logic               m_valid_reg,  m_valid_next;
    logic [CNT_W-1:0]   m_length_reg, m_length_next;
    logic [CNT_W-1:0]   m_cursor_reg, m_cursor_next;
    logic               m_rvalid_reg, m_rvalid_next;
    logic               m_found_reg,  m_found_next;
    logic [TUPLE_W-1:0] m_data_reg,   m_data_next;

    // memory port controls
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [TUPLE_W-1:0] mem_wdata;

    // command conditions, all against the state before the command
    logic [CNT_W:0]     cur_inc;
    logic [CNT_W:0]     idx_inc;
    logic [CNT_W-1:0]   idx_dec;
    logic [CNT_W-1:0]   ins_pos;
    logic               has_entry;
    logic               can_insert;
    logic               can_swap_next;
    logic               can_swap_prev;
    logic               can_fwd;
    logic               result_free;

    assign cur_inc       = {1'b0, cursor_reg} + {1'b0, ONE_C};
    assign idx_inc       = {1'b0, idx_reg} + {1'b0, ONE_C};
    assign idx_dec       = idx_reg - ONE_C;
    assign has_entry     = cursor_reg < count_reg;
    assign can_insert    = count_reg < DEPTH_C;
    assign can_fwd       = cur_inc < {1'b0, count_reg};
    assign can_swap_next = can_fwd;
    assign can_swap_prev = (cursor_reg != '0) && has_entry;
    assign result_free   = !m_valid_reg || m_ready;

    // insert lands after the cursor, at 0 when empty, appended when cursor sits at length
    always_comb begin
        if (count_reg == '0) begin
            ins_pos = '0;
        end else if (cur_inc > {1'b0, count_reg}) begin
            ins_pos = count_reg;
        end else begin
            ins_pos = cur_inc[CNT_W-1:0];
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_mode)
                        MODE_INSERT:    state_next = can_insert ? ST_INS_RD : ST_DONE;
                        MODE_REMOVE:    state_next = has_entry ? ST_REM_RD : ST_DONE;
                        MODE_SWAP_NEXT: state_next = can_swap_next ? ST_SWP_RD1 : ST_DONE;
                        MODE_SWAP_PREV: state_next = can_swap_prev ? ST_SWP_RD1 : ST_DONE;
                        MODE_READ:      state_next = has_entry ? ST_READ_RD : ST_DONE;
                        MODE_WRITE:     state_next = has_entry ? ST_WRITE : ST_DONE;
                        MODE_CONTAINS:  state_next = ST_SCAN;
                        default:        state_next = ST_DONE;
                    endcase
                end
            end
            ST_INS_RD:  state_next = (idx_reg == pos_reg) ? ST_DONE : ST_INS_WR;
            ST_INS_WR:  state_next = ST_INS_RD;
            ST_REM_RD:  state_next = (idx_inc >= {1'b0, count_reg}) ? ST_DONE : ST_REM_WR;
            ST_REM_WR:  state_next = ST_REM_RD;
            ST_SWP_RD1: state_next = ST_SWP_RD2;
            ST_SWP_RD2: state_next = ST_SWP_WR1;
            ST_SWP_WR1: state_next = ST_SWP_WR2;
            ST_SWP_WR2: state_next = ST_DONE;
            ST_READ_RD: state_next = ST_DONE;
            ST_WRITE:   state_next = ST_DONE;
            ST_SCAN:    state_next = (idx_reg >= count_reg) ? ST_DONE : ST_SCAN;
            ST_DONE:    state_next = result_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        tuple_next    = tuple_reg;
        hold_next     = hold_reg;
        rvalid_next   = rvalid_reg;
        hit_next      = hit_reg;
        pend_next     = pend_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[IDX_W-1:0];
        mem_we        = 1'b0;
        mem_waddr     = idx_reg[IDX_W-1:0];
        mem_wdata     = tuple_reg;
        // a waiting result leaves once taken
        m_valid_next  = m_valid_reg && !m_ready;
        m_length_next = m_length_reg;
        m_cursor_next = m_cursor_reg;
        m_rvalid_next = m_rvalid_reg;
        m_found_next  = m_found_reg;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    tuple_next  = {s_word_e, s_word_d, s_word_c, s_word_b, s_word_a};
                    rvalid_next = 1'b0;
                    hit_next    = 1'b0;
                    pend_next   = 1'b0;
                    unique case (s_mode)
                        MODE_CLEAR: begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        MODE_INSERT: begin
                            idx_next = count_reg;
                            pos_next = ins_pos;
                        end
                        MODE_REMOVE: begin
                            idx_next = cursor_reg;
                        end
                        MODE_SWAP_NEXT: begin
                            idx_next = cursor_reg;
                            pos_next = cur_inc[CNT_W-1:0];
                        end
                        MODE_SWAP_PREV: begin
                            idx_next = cursor_reg;
                            pos_next = cursor_reg - ONE_C;
                        end
                        MODE_FWD: begin
                            if (can_fwd) begin
                                cursor_next = cur_inc[CNT_W-1:0];
                            end
                        end
                        MODE_BACK: begin
                            if (cursor_reg != '0) begin
                                cursor_next = cursor_reg - ONE_C;
                            end
                        end
                        MODE_CONTAINS: begin
                            idx_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INS_RD: begin
                if (idx_reg == pos_reg) begin
                    // hole is open, drop the new tuple in
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[IDX_W-1:0];
                    mem_wdata  = tuple_reg;
                    count_next = count_reg + ONE_C;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_dec[IDX_W-1:0];
                end
            end
            ST_INS_WR: begin
                // slide entry up by one
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
                idx_next  = idx_dec;
            end
            ST_REM_RD: begin
                if (idx_inc >= {1'b0, count_reg}) begin
                    count_next = count_reg - ONE_C;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[IDX_W-1:0];
                end
            end
            ST_REM_WR: begin
                // slide entry down by one
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
                idx_next  = idx_inc[CNT_W-1:0];
            end
            ST_SWP_RD1: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[IDX_W-1:0];
            end
            ST_SWP_RD2: begin
                rd_en     = 1'b1;
                rd_addr   = pos_reg[IDX_W-1:0];
                hold_next = rd_data_reg;
            end
            ST_SWP_WR1: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
            end
            ST_SWP_WR2: begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[IDX_W-1:0];
                mem_wdata = hold_reg;
            end
            ST_READ_RD: begin
                rd_en       = 1'b1;
                rd_addr     = cursor_reg[IDX_W-1:0];
                rvalid_next = 1'b1;
            end
            ST_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = cursor_reg[IDX_W-1:0];
                mem_wdata = tuple_reg;
            end
            ST_SCAN: begin
                // read one entry a cycle, compare it the cycle after
                if (pend_reg && (rd_data_reg == tuple_reg)) begin
                    hit_next = 1'b1;
                end
                if (idx_reg < count_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg[IDX_W-1:0];
                    idx_next = idx_inc[CNT_W-1:0];
                end
                pend_next = (idx_reg < count_reg);
            end
            ST_DONE: begin
                if (result_free) begin
                    m_valid_next  = 1'b1;
                    m_length_next = count_reg;
                    m_cursor_next = cursor_reg;
                    m_rvalid_next = rvalid_reg;
                    m_found_next  = hit_reg;
                    m_data_next   = rvalid_reg ? rd_data_reg : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cursor_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        tuple_reg    <= tuple_next;
        hold_reg     <= hold_next;
        rvalid_reg   <= rvalid_next;
        hit_reg      <= hit_next;
        m_length_reg <= m_length_next;
        m_cursor_reg <= m_cursor_next;
        m_rvalid_reg <= m_rvalid_next;
        m_found_reg  <= m_found_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_list_length = m_length_reg;
    assign m_cursor_pos  = m_cursor_reg;
    assign m_read_valid  = m_rvalid_reg;
    assign m_found       = m_found_reg;
    assign m_out_a       = m_data_reg[0*WORD_W +: WORD_W];
    assign m_out_b       = m_data_reg[1*WORD_W +: WORD_W];
    assign m_out_c       = m_data_reg[2*WORD_W +: WORD_W];
    assign m_out_d       = m_data_reg[3*WORD_W +: WORD_W];
    assign m_out_e       = m_data_reg[4*WORD_W +: WORD_W];

    // cursor never passes the length, length never passes the depth
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cursor_reg <= count_reg) && (count_reg <= DEPTH_C))
        else $error("cursor or length out of range");

    // length moves by one at a time, or drops to zero on clear
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            (count_reg == '0) || (count_reg == $past(count_reg) + ONE_C) ||
            (count_reg == $past(count_reg) - ONE_C))
        else $error("length jumped");

    // the walking index stays within the list while shifting or scanning
    a_walk_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS_RD || state_reg == ST_INS_WR || state_reg == ST_REM_RD ||
         state_reg == ST_REM_WR || state_reg == ST_SCAN) |-> (idx_reg <= count_reg))
        else $error("walk index past length");

    // insert hole walks down toward the landing place, never below it
    a_insert_hole: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INS_RD || state_reg == ST_INS_WR) |-> (pos_reg <= idx_reg))
        else $error("insert hole below landing place");

endmodule
